### sv/easpe_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// easpe_pkg: shared types and constants of the encoder angle/speed estimator
// Widths, register map, reset values and the speed scale factor.
// -----------------------------------------------------------------------------
package easpe_pkg;

  // Encoder resolution: one revolution is 4096 counts, so all wraps are masks.
  localparam int unsigned CountsPerRev = 4096;
  localparam int unsigned AngleW       = 12;
  localparam int unsigned PoleW        = 5;
  localparam int unsigned SpeedW       = 23;
  localparam int unsigned DiffW        = 14;
  localparam int unsigned ScaleW       = 12;

  localparam logic signed [DiffW-1:0]  HalfRev      = DiffW'(CountsPerRev / 2);
  localparam logic signed [DiffW-1:0]  FullRev      = DiffW'(CountsPerRev);
  localparam logic signed [ScaleW-1:0] SpeedScaleQ7 = ScaleW'(1875);

  localparam int unsigned SpeedWindowLenDefault = 40;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegZeroOffset = 1'b0;
  localparam logic        RegPolePairs  = 1'b1;

  localparam logic [AngleW-1:0] ZeroOffsetRst = '0;
  localparam logic [PoleW-1:0]  PolePairsRst  = PoleW'(3);

  typedef struct packed {
    logic [AngleW-1:0] zero_offset;
    logic [PoleW-1:0]  pp_count;
  } cfg_t;

endpackage

### sv/easpe_cfg_regs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// easpe_cfg_regs: configuration register file
// APB-style write/read of zero offset and pole pairs; decode on word address.
// -----------------------------------------------------------------------------
module easpe_cfg_regs import easpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegZeroOffset: cfg_d.zero_offset = pwdata[AngleW-1:0];
        RegPolePairs:  cfg_d.pp_count    = pwdata[PoleW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_offset <= ZeroOffsetRst;
      cfg_q.pp_count    <= PolePairsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      RegZeroOffset: prdata = ApbDataW'(cfg_q.zero_offset);
      RegPolePairs:  prdata = ApbDataW'(cfg_q.pp_count);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/easpe_hist_ring.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// easpe_hist_ring: angle history ring
// One-port memory read and written at the ring pointer in the same cycle
// (read returns the old entry); per-entry valid bits make unwritten entries
// read as zero.
// -----------------------------------------------------------------------------
module easpe_hist_ring import easpe_pkg::*; #(
  parameter int unsigned SpeedWindowLen = SpeedWindowLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AngleW-1:0] wr_angle_i,
  output logic [AngleW-1:0] old_angle_o
);

  localparam int unsigned PtrW = $clog2(SpeedWindowLen);

  logic [AngleW-1:0]         mem [SpeedWindowLen];
  logic [AngleW-1:0]         rd_data_q;
  logic                      rd_valid_q;
  logic [SpeedWindowLen-1:0] valid_q;
  logic [PtrW-1:0]           ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (wr_en_i) begin
      if (ptr_q == PtrW'(SpeedWindowLen - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PtrW'(1);
      end
    end
  end

  // Storage: read-first, so the entry leaving the window comes out as the
  // new angle replaces it.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_data_q  <= mem[ptr_q];
      mem[ptr_q] <= wr_angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (wr_en_i) begin
        rd_valid_q     <= valid_q[ptr_q];
        valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  assign old_angle_o = rd_valid_q ? rd_data_q : '0;

endmodule

### sv/encoder_angle_speed_estimator_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// encoder_angle_speed_estimator_core: encoder angle and windowed speed
// Turns raw quadrature counter samples into mechanical angle, electrical
// angle and speed in rpm (Q7).
// -----------------------------------------------------------------------------
// The block takes one counter sample per clock while the output side is not
// stalled and returns one result beat per sample through the stage-1 and
// output registers. Mechanical angle is (zero_offset - count) mod 4096,
// electrical angle is mechanical angle times the pole-pair count mod 4096, and
// speed is the difference against the angle seen SpeedWindowLen samples
// earlier, unwrapped to half a revolution and multiplied by 1875 (rpm, seven
// fraction bits). The history sits in a one-port ring memory that is read and
// written at the same entry in the acceptance cycle, so the sustained rate is
// one beat per clock while the output is not stalled; the per-entry valid bits
// cleared at reset make the first window measure against angle zero without
// any clearing pass. Write configuration only while the block is idle.
// -----------------------------------------------------------------------------
module encoder_angle_speed_estimator_core import easpe_pkg::*; #(
  parameter int unsigned SpeedWindowLen = SpeedWindowLenDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample input; tdata: [11:0] encoder_count, [15:12] zero
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Result output; tdata: [11:0] mech_angle, [23:12] elec_angle,
  // [46:24] speed_rpm_q7, [47] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  easpe_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage 0: align the count and form the electrical angle.
  logic                      in_beat;
  logic [AngleW-1:0]         count;
  logic [AngleW-1:0]         mech;
  logic [AngleW+PoleW-1:0]   elec_prod;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign count     = s_axis_tdata[AngleW-1:0];
  assign mech      = cfg.zero_offset - count;
  assign elec_prod = (AngleW+PoleW)'(mech) * (AngleW+PoleW)'(cfg.pp_count);

  logic [AngleW-1:0] old_angle;

  easpe_hist_ring #(
    .SpeedWindowLen (SpeedWindowLen)
  ) u_hist_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_beat),
    .wr_angle_i  (mech),
    .old_angle_o (old_angle)
  );

  // Stage 1: holds the angles while the ring read completes.
  logic              s1_valid_q;
  logic [AngleW-1:0] s1_mech_q;
  logic [AngleW-1:0] s1_elec_q;
  logic              s1_adv;

  assign s1_adv        = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_mech_q <= mech;
      s1_elec_q <= elec_prod[AngleW-1:0];
    end
  end

  // Unwrap the window difference to half a revolution, then scale.
  logic signed [DiffW-1:0]        diff_raw;
  logic signed [DiffW-1:0]        diff;
  logic signed [DiffW+ScaleW-1:0] speed_prod;

  always_comb begin
    diff_raw = $signed(DiffW'(s1_mech_q)) - $signed(DiffW'(old_angle));
    if (diff_raw > HalfRev) begin
      diff = diff_raw - FullRev;
    end else if (diff_raw < -HalfRev) begin
      diff = diff_raw + FullRev;
    end else begin
      diff = diff_raw;
    end
    speed_prod = diff * SpeedScaleQ7;
  end

  // Output register.
  logic              out_valid_q;
  logic [AngleW-1:0] out_mech_q;
  logic [AngleW-1:0] out_elec_q;
  logic [SpeedW-1:0] out_speed_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_mech_q  <= s1_mech_q;
      out_elec_q  <= s1_elec_q;
      out_speed_q <= speed_prod[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_speed_q, out_elec_q, out_mech_q};

  // A stalled stage-1 beat is never dropped.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("stage-1 beat lost while stalled");

  // Every accepted sample lands in stage 1.
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> s1_valid_q)
    else $error("accepted sample missing from stage 1");

  // Unwrapped difference stays within half a revolution.
  a_diff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (diff <= HalfRev) && (diff >= -HalfRev))
    else $error("speed difference out of range");

  // A result advanced into the output register is presented next cycle.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid)
    else $error("result not presented after advance");

endmodule
